### rtl/rv32_execute_unit_assert.svh
// Assertion macros for the execute unit.
`ifndef RV32_EXECUTE_UNIT_ASSERT_SVH
`define RV32_EXECUTE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define RV32EU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RV32EU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RV32EU_ASSERT(lbl, prop, msg)
`define RV32EU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/rv32eu_pkg.sv
// Shared constants, opcodes and types of the execute unit.
package rv32eu_pkg;

  localparam int XLEN        = 32;
  localparam int MEM_AW      = 12;
  localparam int MEM_WORDS   = 1 << MEM_AW;
  localparam int CSR_AW      = 12;
  localparam int CSR_ENTRIES = 1 << CSR_AW;

  typedef logic [XLEN-1:0] word_t;

  localparam logic [5:0] OP_ADD    = 6'd0;
  localparam logic [5:0] OP_SUB    = 6'd1;
  localparam logic [5:0] OP_MUL    = 6'd2;
  localparam logic [5:0] OP_DIV    = 6'd3;
  localparam logic [5:0] OP_LW     = 6'd4;
  localparam logic [5:0] OP_SW     = 6'd5;
  localparam logic [5:0] OP_JAL    = 6'd6;
  localparam logic [5:0] OP_JALR   = 6'd7;
  localparam logic [5:0] OP_ECALL  = 6'd8;
  localparam logic [5:0] OP_ADDI   = 6'd9;
  localparam logic [5:0] OP_ANDI   = 6'd10;
  localparam logic [5:0] OP_ORI    = 6'd11;
  localparam logic [5:0] OP_SLTI   = 6'd12;
  localparam logic [5:0] OP_XORI   = 6'd13;
  localparam logic [5:0] OP_SLTIU  = 6'd14;
  localparam logic [5:0] OP_LUI    = 6'd15;
  localparam logic [5:0] OP_AUIPC  = 6'd16;
  localparam logic [5:0] OP_SLLI   = 6'd17;
  localparam logic [5:0] OP_SRLI   = 6'd18;
  localparam logic [5:0] OP_SRAI   = 6'd19;
  localparam logic [5:0] OP_SLL    = 6'd20;
  localparam logic [5:0] OP_SRL    = 6'd21;
  localparam logic [5:0] OP_SRA    = 6'd22;
  localparam logic [5:0] OP_BEQ    = 6'd23;
  localparam logic [5:0] OP_BNE    = 6'd24;
  localparam logic [5:0] OP_BLT    = 6'd25;
  localparam logic [5:0] OP_BLTU   = 6'd26;
  localparam logic [5:0] OP_BGEU   = 6'd27;
  localparam logic [5:0] OP_BGE    = 6'd28;
  localparam logic [5:0] OP_XOR    = 6'd29;
  localparam logic [5:0] OP_CSRRW  = 6'd30;
  localparam logic [5:0] OP_CSRRS  = 6'd31;
  localparam logic [5:0] OP_CSRRC  = 6'd32;
  localparam logic [5:0] OP_CSRRWI = 6'd33;
  localparam logic [5:0] OP_CSRRSI = 6'd34;
  localparam logic [5:0] OP_CSRRCI = 6'd35;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DIV0  = 2'd1;
  localparam logic [1:0] ST_UNIMP = 2'd2;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [CSR_AW-1:0] addr;
    word_t             wdata;
  } csr_req_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

endpackage

### rtl/rv32eu_regfile.sv
// Register file with two registered read ports; x0 and unwritten entries read zero.
module rv32eu_regfile (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [4:0]          raddr_a,
  input  logic [4:0]          raddr_b,
  input  logic                we,
  input  logic [4:0]          waddr,
  input  rv32eu_pkg::word_t   wdata,
  output rv32eu_pkg::word_t   rdata_a,
  output rv32eu_pkg::word_t   rdata_b
);

  rv32eu_pkg::word_t mem_r [32];
  logic [31:0]       valid_r;
  rv32eu_pkg::word_t rdata_a_r;
  rv32eu_pkg::word_t rdata_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we && waddr != 5'd0) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_a_r <= valid_r[raddr_a] ? mem_r[raddr_a] : '0;
      rdata_b_r <= valid_r[raddr_b] ? mem_r[raddr_b] : '0;
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

### rtl/rv32eu_csr_file.sv
// CSR storage with a clearing sweep after reset and a registered read port.
module rv32eu_csr_file (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rv32eu_pkg::csr_req_t req,
  output rv32eu_pkg::word_t    rdata,
  output logic                 busy
);

  rv32eu_pkg::word_t             mem_r [rv32eu_pkg::CSR_ENTRIES];
  logic [rv32eu_pkg::CSR_AW:0]   clr_idx_r;
  rv32eu_pkg::word_t             rdata_r;
  logic                          clr_busy;

  assign clr_busy = !clr_idx_r[rv32eu_pkg::CSR_AW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (clr_busy) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      mem_r[clr_idx_r[rv32eu_pkg::CSR_AW-1:0]] <= '0;
    end else if (req.wr_en) begin
      mem_r[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem_r[req.addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clr_busy;

endmodule

### rtl/rv32eu_divider.sv
// Iterative restoring divider on unsigned magnitudes, one quotient bit per cycle.
module rv32eu_divider (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rv32eu_pkg::div_req_t req,
  output logic                 done,
  output rv32eu_pkg::word_t    quotient
);

  rv32eu_pkg::word_t q_r;
  rv32eu_pkg::word_t rem_r;
  rv32eu_pkg::word_t dvs_r;
  logic [5:0]        cnt_r;
  logic [33:0]       trial;

  assign trial = {1'b0, rem_r, q_r[31]} - {2'b00, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (req.start) begin
      cnt_r <= 6'd32;
    end else if (cnt_r != 6'd0) begin
      cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      q_r   <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (cnt_r != 6'd0) begin
      if (!trial[33]) begin
        rem_r <= trial[31:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], q_r[31]};
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

  assign done     = (cnt_r == 6'd1);
  assign quotient = q_r;

endmodule

### rtl/rv32_execute_unit.sv
// Top level of the execute unit: sequencer, ALU, data memory and result register.
//
//   channel | direction | ports
//   in_     | input     | in_valid, in_stall, opcode/register/immediate/csr/pc fields
//   out_    | output    | out_valid, out_stall, write value, taken, next pc, halt, status
//
// Most instructions pass from the accepted beat through the EXEC and FIN states to the result beat.
// DIV with a nonzero divisor also waits in the DIV state for the one-bit-per-cycle divider.
// After reset the CSR file is swept to zero, and no beat is taken during the sweep.
// A result beat held by out_stall holds the next instruction in FIN, delaying its write-back and any new beat.
`include "rv32_execute_unit_assert.svh"
module rv32_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_opcode,
  input  logic [4:0]  in_dest_reg,
  input  logic [4:0]  in_src_reg_a,
  input  logic [4:0]  in_src_reg_b,
  input  logic signed [31:0] in_immediate,
  input  logic [11:0] in_csr_addr,
  input  logic [31:0] in_cur_pc,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_write_value,
  output logic        out_taken,
  output logic [31:0] out_next_pc,
  output logic        out_halt,
  output logic [1:0]  out_status
);

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [1:0] SEL_ALU  = 2'd0;
  localparam logic [1:0] SEL_LOAD = 2'd1;
  localparam logic [1:0] SEL_CSR  = 2'd2;
  localparam logic [1:0] SEL_DIV  = 2'd3;

  logic [2:0] state_r, state_nxt;

  logic [5:0]        op_r;
  logic [4:0]        rd_r;
  logic [4:0]        ra_r;
  rv32eu_pkg::word_t imm_r;
  logic [11:0]       csr_addr_r;
  rv32eu_pkg::word_t pc_r;

  rv32eu_pkg::word_t res_r, res_nxt;
  logic              wr_r, wr_nxt;
  logic              tk_r, tk_nxt;
  rv32eu_pkg::word_t npc_r, npc_nxt;
  logic              hlt_r, hlt_nxt;
  logic [1:0]        st_r, st_nxt;
  logic [1:0]        sel_r, sel_nxt;
  logic              neg_q_r;
  rv32eu_pkg::word_t store_r;
  rv32eu_pkg::word_t csr_opnd_r, csr_opnd_nxt;
  logic              csr_ok_r;
  logic [rv32eu_pkg::MEM_AW-1:0] mem_idx_r;

  logic              out_valid_r;
  rv32eu_pkg::word_t out_val_r;
  logic              out_tk_r;
  rv32eu_pkg::word_t out_npc_r;
  logic              out_hlt_r;
  logic [1:0]        out_st_r;

  rv32eu_pkg::word_t data_mem_r [rv32eu_pkg::MEM_WORDS];
  rv32eu_pkg::word_t mem_rdata_r;

  rv32eu_pkg::word_t rf_a, rf_b, rf_wdata;
  logic              rf_we;
  rv32eu_pkg::csr_req_t csr_req;
  rv32eu_pkg::word_t csr_rdata, csr_old, csr_new;
  logic              csr_busy;
  rv32eu_pkg::div_req_t div_req;
  logic              div_done;
  rv32eu_pkg::word_t div_q;

  logic              accept, fin_go;
  logic              is_csr, is_csr_x;
  rv32eu_pkg::word_t add_a, add_b, sum, seq, fin_val;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign fin_go = (state_r == S_FIN) && !(out_valid_r && out_stall);
  assign is_csr = (op_r >= rv32eu_pkg::OP_CSRRW) && (op_r <= rv32eu_pkg::OP_CSRRCI);
  assign is_csr_x = (op_r >= rv32eu_pkg::OP_CSRRWI);

  rv32eu_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .raddr_a (in_src_reg_a),
    .raddr_b (in_src_reg_b),
    .we      (rf_we),
    .waddr   (rd_r),
    .wdata   (rf_wdata),
    .rdata_a (rf_a),
    .rdata_b (rf_b)
  );

  rv32eu_csr_file u_csr_file (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (csr_req),
    .rdata (csr_rdata),
    .busy  (csr_busy)
  );

  rv32eu_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    add_a = rf_a;
    add_b = imm_r;
    case (op_r)
      rv32eu_pkg::OP_ADD:   add_b = rf_b;
      rv32eu_pkg::OP_SUB:   add_b = ~rf_b + 32'd1;
      rv32eu_pkg::OP_AUIPC: begin
        add_a = pc_r;
        add_b = {imm_r[19:0], 12'd0};
      end
      rv32eu_pkg::OP_JAL, rv32eu_pkg::OP_BEQ, rv32eu_pkg::OP_BNE, rv32eu_pkg::OP_BLT,
      rv32eu_pkg::OP_BLTU, rv32eu_pkg::OP_BGEU, rv32eu_pkg::OP_BGE: add_a = pc_r;
      default: add_b = imm_r;
    endcase
  end

  assign sum = add_a + add_b;
  assign seq = pc_r + 32'd4;

  always_comb begin
    res_nxt = '0;
    wr_nxt  = 1'b1;
    tk_nxt  = 1'b0;
    npc_nxt = seq;
    hlt_nxt = 1'b0;
    st_nxt  = rv32eu_pkg::ST_OK;
    sel_nxt = SEL_ALU;
    csr_opnd_nxt = is_csr_x ? {27'd0, ra_r} : rf_a;
    case (op_r)
      rv32eu_pkg::OP_ADD, rv32eu_pkg::OP_SUB, rv32eu_pkg::OP_ADDI,
      rv32eu_pkg::OP_AUIPC: res_nxt = sum;
      rv32eu_pkg::OP_MUL:   res_nxt = rf_a * rf_b;
      rv32eu_pkg::OP_DIV: begin
        if (rf_b == '0) begin
          st_nxt = rv32eu_pkg::ST_DIV0;
          wr_nxt = 1'b0;
        end else begin
          sel_nxt = SEL_DIV;
        end
      end
      rv32eu_pkg::OP_LW:    sel_nxt = SEL_LOAD;
      rv32eu_pkg::OP_SW:    wr_nxt = 1'b0;
      rv32eu_pkg::OP_JAL: begin
        res_nxt = seq;
        tk_nxt  = 1'b1;
        npc_nxt = sum;
      end
      rv32eu_pkg::OP_JALR: begin
        res_nxt = seq;
        tk_nxt  = 1'b1;
        npc_nxt = {sum[31:1], 1'b0};
      end
      rv32eu_pkg::OP_ECALL: begin
        hlt_nxt = 1'b1;
        wr_nxt  = 1'b0;
      end
      rv32eu_pkg::OP_ANDI:  res_nxt = rf_a & imm_r;
      rv32eu_pkg::OP_ORI:   res_nxt = rf_a | imm_r;
      rv32eu_pkg::OP_SLTI:  res_nxt = {31'd0, $signed(rf_a) < $signed(imm_r)};
      rv32eu_pkg::OP_XORI:  res_nxt = rf_a ^ imm_r;
      rv32eu_pkg::OP_SLTIU: res_nxt = {31'd0, rf_a < imm_r};
      rv32eu_pkg::OP_LUI:   res_nxt = {imm_r[19:0], 12'd0};
      rv32eu_pkg::OP_SLLI:  res_nxt = rf_a << imm_r[4:0];
      rv32eu_pkg::OP_SRLI:  res_nxt = rf_a >> imm_r[4:0];
      rv32eu_pkg::OP_SRAI:  res_nxt = $unsigned($signed(rf_a) >>> imm_r[4:0]);
      rv32eu_pkg::OP_SLL:   res_nxt = rf_a << rf_b[4:0];
      rv32eu_pkg::OP_SRL:   res_nxt = rf_a >> rf_b[4:0];
      rv32eu_pkg::OP_SRA:   res_nxt = $unsigned($signed(rf_a) >>> rf_b[4:0]);
      rv32eu_pkg::OP_BEQ, rv32eu_pkg::OP_BNE, rv32eu_pkg::OP_BLT,
      rv32eu_pkg::OP_BLTU, rv32eu_pkg::OP_BGEU, rv32eu_pkg::OP_BGE: begin
        wr_nxt = 1'b0;
        case (op_r)
          rv32eu_pkg::OP_BEQ:  tk_nxt = (rf_a == rf_b);
          rv32eu_pkg::OP_BNE:  tk_nxt = (rf_a != rf_b);
          rv32eu_pkg::OP_BLT:  tk_nxt = $signed(rf_a) < $signed(rf_b);
          rv32eu_pkg::OP_BLTU: tk_nxt = rf_a < rf_b;
          rv32eu_pkg::OP_BGEU: tk_nxt = rf_a >= rf_b;
          default:             tk_nxt = !($signed(rf_a) < $signed(rf_b));
        endcase
        if (tk_nxt) begin
          npc_nxt = sum;
        end
      end
      rv32eu_pkg::OP_XOR:   res_nxt = rf_a ^ rf_b;
      rv32eu_pkg::OP_CSRRW, rv32eu_pkg::OP_CSRRS, rv32eu_pkg::OP_CSRRC,
      rv32eu_pkg::OP_CSRRWI, rv32eu_pkg::OP_CSRRSI, rv32eu_pkg::OP_CSRRCI:
        sel_nxt = SEL_CSR;
      default: begin
        st_nxt = rv32eu_pkg::ST_UNIMP;
        wr_nxt = 1'b0;
      end
    endcase
  end

  assign div_req.start    = (state_r == S_EXEC) && (op_r == rv32eu_pkg::OP_DIV) &&
                            (rf_b != '0);
  assign div_req.dividend = rf_a[31] ? (~rf_a + 32'd1) : rf_a;
  assign div_req.divisor  = rf_b[31] ? (~rf_b + 32'd1) : rf_b;

  assign csr_old = csr_ok_r ? csr_rdata : '0;
  always_comb begin
    case (op_r)
      rv32eu_pkg::OP_CSRRS, rv32eu_pkg::OP_CSRRSI: csr_new = csr_old | csr_opnd_r;
      rv32eu_pkg::OP_CSRRC, rv32eu_pkg::OP_CSRRCI: csr_new = csr_old & ~csr_opnd_r;
      default:                                     csr_new = csr_opnd_r;
    endcase
  end

  assign csr_req.rd_en = (state_r == S_EXEC);
  assign csr_req.wr_en = fin_go && is_csr && csr_ok_r;
  assign csr_req.addr  = csr_addr_r[rv32eu_pkg::CSR_AW-1:0];
  assign csr_req.wdata = csr_new;

  always_comb begin
    case (sel_r)
      SEL_LOAD: fin_val = mem_rdata_r;
      SEL_CSR:  fin_val = csr_old;
      SEL_DIV:  fin_val = neg_q_r ? (~div_q + 32'd1) : div_q;
      default:  fin_val = res_r;
    endcase
  end

  assign rf_we    = fin_go && wr_r && (rd_r != 5'd0);
  assign rf_wdata = fin_val;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (!csr_busy) state_nxt = S_IDLE;
      S_IDLE: if (accept) state_nxt = S_EXEC;
      S_EXEC: state_nxt = div_req.start ? S_DIV : S_FIN;
      S_DIV:  if (div_done) state_nxt = S_FIN;
      S_FIN:  if (fin_go) state_nxt = S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_opcode;
      rd_r       <= in_dest_reg;
      ra_r       <= in_src_reg_a;
      imm_r      <= in_immediate;
      csr_addr_r <= in_csr_addr;
      pc_r       <= in_cur_pc;
    end
    if (state_r == S_EXEC) begin
      res_r      <= res_nxt;
      wr_r       <= wr_nxt;
      tk_r       <= tk_nxt;
      npc_r      <= npc_nxt;
      hlt_r      <= hlt_nxt;
      st_r       <= st_nxt;
      sel_r      <= sel_nxt;
      neg_q_r    <= rf_a[31] ^ rf_b[31];
      store_r    <= rf_b;
      csr_opnd_r <= csr_opnd_nxt;
      csr_ok_r   <= {20'd0, csr_addr_r} < 32'(rv32eu_pkg::CSR_ENTRIES);
      mem_idx_r  <= sum[2 +: rv32eu_pkg::MEM_AW];
      mem_rdata_r <= data_mem_r[sum[2 +: rv32eu_pkg::MEM_AW]];
    end
    if (fin_go && op_r == rv32eu_pkg::OP_SW) begin
      data_mem_r[mem_idx_r] <= store_r;
    end
    if (fin_go) begin
      out_val_r <= (wr_r && rd_r != 5'd0) ? fin_val : '0;
      out_tk_r  <= tk_r;
      out_npc_r <= npc_r;
      out_hlt_r <= hlt_r;
      out_st_r  <= st_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_write_value = out_val_r;
  assign out_taken       = out_tk_r;
  assign out_next_pc     = out_npc_r;
  assign out_halt        = out_hlt_r;
  assign out_status      = out_st_r;

  `RV32EU_ASSERT(a_err_no_write, (out_valid && out_status != rv32eu_pkg::ST_OK) |-> (out_write_value == '0 && !out_taken), "error beat carries a value or redirect")
  `RV32EU_ASSERT(a_clr_blocks, (state_r == S_CLR) |-> in_stall, "beat accepted during CSR clear")
  `RV32EU_ASSERT_NEXT(a_div_start, div_req.start, (state_r == S_DIV), "divider started outside DIV sequence")

endmodule

### dv/tb.sv
// Self-checking testbench for the RV32 execute unit with random stimulus and handshake gaps.
module tb;

  typedef struct packed {
    logic [31:0] wval;
    logic        taken;
    logic [31:0] npc;
    logic        halt;
    logic [1:0]  status;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [5:0] in_opcode = '0;
  logic [4:0] in_dest_reg = '0;
  logic [4:0] in_src_reg_a = '0;
  logic [4:0] in_src_reg_b = '0;
  logic signed [31:0] in_immediate = '0;
  logic [11:0] in_csr_addr = '0;
  logic [31:0] in_cur_pc = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [31:0] out_write_value;
  logic out_taken;
  logic [31:0] out_next_pc;
  logic out_halt;
  logic [1:0] out_status;

  logic [31:0] gpr [32];
  logic [31:0] dmem [rv32eu_pkg::MEM_WORDS];
  bit dmem_set [rv32eu_pkg::MEM_WORDS];
  logic [31:0] csrs [rv32eu_pkg::CSR_ENTRIES];
  exec_result_t pending_results[$];
  int mismatches = 0;
  int ostall_left = 0;

  rv32_execute_unit u_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] gpr_read(logic [4:0] idx);
    return idx == 5'd0 ? 32'd0 : gpr[idx];
  endfunction

  function automatic logic [11:0] word_index(logic [31:0] addr);
    return addr[13:2];
  endfunction

  function automatic exec_result_t execute(logic [5:0] op, logic [4:0] rd, logic [4:0] ra,
                                           logic [4:0] rb, logic [31:0] imm,
                                           logic [11:0] csr, logic [31:0] pc);
    logic [31:0] a, b, val, old, qa, qb, q;
    logic wr, tk;
    exec_result_t r;
    a = gpr_read(ra);
    b = gpr_read(rb);
    val = 0; wr = 0; tk = 0;
    r = '0;
    r.npc = pc + 32'd4;
    old = csrs[csr];
    case (op)
      rv32eu_pkg::OP_ADD: begin val = a + b; wr = 1; end
      rv32eu_pkg::OP_SUB: begin val = a - b; wr = 1; end
      rv32eu_pkg::OP_MUL: begin val = a * b; wr = 1; end
      rv32eu_pkg::OP_DIV: begin
        if (b == 0) r.status = rv32eu_pkg::ST_DIV0;
        else begin
          qa = a[31] ? -a : a;
          qb = b[31] ? -b : b;
          q = qa / qb;
          val = (a[31] != b[31]) ? -q : q;
          wr = 1;
        end
      end
      rv32eu_pkg::OP_LW: begin val = dmem[word_index(a + imm)]; wr = 1; end
      rv32eu_pkg::OP_SW: begin
        dmem[word_index(a + imm)] = b;
        dmem_set[word_index(a + imm)] = 1;
      end
      rv32eu_pkg::OP_JAL: begin val = pc + 4; wr = 1; tk = 1; r.npc = pc + imm; end
      rv32eu_pkg::OP_JALR: begin
        val = pc + 4; wr = 1; tk = 1; r.npc = (a + imm) & ~32'd1;
      end
      rv32eu_pkg::OP_ECALL: r.halt = 1;
      rv32eu_pkg::OP_ADDI: begin val = a + imm; wr = 1; end
      rv32eu_pkg::OP_ANDI: begin val = a & imm; wr = 1; end
      rv32eu_pkg::OP_ORI: begin val = a | imm; wr = 1; end
      rv32eu_pkg::OP_SLTI: begin val = {31'd0, $signed(a) < $signed(imm)}; wr = 1; end
      rv32eu_pkg::OP_XORI: begin val = a ^ imm; wr = 1; end
      rv32eu_pkg::OP_SLTIU: begin val = {31'd0, a < imm}; wr = 1; end
      rv32eu_pkg::OP_LUI: begin val = imm << 12; wr = 1; end
      rv32eu_pkg::OP_AUIPC: begin val = pc + (imm << 12); wr = 1; end
      rv32eu_pkg::OP_SLLI: begin val = a << imm[4:0]; wr = 1; end
      rv32eu_pkg::OP_SRLI: begin val = a >> imm[4:0]; wr = 1; end
      rv32eu_pkg::OP_SRAI: begin val = $signed(a) >>> imm[4:0]; wr = 1; end
      rv32eu_pkg::OP_SLL: begin val = a << b[4:0]; wr = 1; end
      rv32eu_pkg::OP_SRL: begin val = a >> b[4:0]; wr = 1; end
      rv32eu_pkg::OP_SRA: begin val = $signed(a) >>> b[4:0]; wr = 1; end
      rv32eu_pkg::OP_BEQ: tk = a == b;
      rv32eu_pkg::OP_BNE: tk = a != b;
      rv32eu_pkg::OP_BLT: tk = $signed(a) < $signed(b);
      rv32eu_pkg::OP_BLTU: tk = a < b;
      rv32eu_pkg::OP_BGEU: tk = a >= b;
      rv32eu_pkg::OP_BGE: tk = $signed(a) >= $signed(b);
      rv32eu_pkg::OP_XOR: begin val = a ^ b; wr = 1; end
      rv32eu_pkg::OP_CSRRW: begin csrs[csr] = a; val = old; wr = 1; end
      rv32eu_pkg::OP_CSRRS: begin csrs[csr] = old | a; val = old; wr = 1; end
      rv32eu_pkg::OP_CSRRC: begin csrs[csr] = old & ~a; val = old; wr = 1; end
      rv32eu_pkg::OP_CSRRWI: begin csrs[csr] = {27'd0, ra}; val = old; wr = 1; end
      rv32eu_pkg::OP_CSRRSI: begin csrs[csr] = old | {27'd0, ra}; val = old; wr = 1; end
      rv32eu_pkg::OP_CSRRCI: begin csrs[csr] = old & ~{27'd0, ra}; val = old; wr = 1; end
      default: r.status = rv32eu_pkg::ST_UNIMP;
    endcase
    if (op >= rv32eu_pkg::OP_BEQ && op <= rv32eu_pkg::OP_BGE && tk) r.npc = pc + imm;
    if (wr && rd != 0) gpr[rd] = val;
    else val = 0;
    r.wval = val;
    r.taken = tk;
    return r;
  endfunction

  function automatic int gap_length();
    int p;
    p = int'($urandom_range(0, 99));
    if (p < 50) return 0;
    if (p < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  task automatic issue(logic [5:0] op, logic [4:0] rd, logic [4:0] ra, logic [4:0] rb,
                       logic [31:0] imm, logic [11:0] csr, logic [31:0] pc);
    int g;
    g = gap_length();
    @(negedge clk);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_opcode <= op; in_dest_reg <= rd; in_src_reg_a <= ra; in_src_reg_b <= rb;
    in_immediate <= imm; in_csr_addr <= csr; in_cur_pc <= pc;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(execute(op, rd, ra, rb, imm, csr, pc));
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (ostall_left == 0) ostall_left = gap_length();
      if (ostall_left > 0) begin
        out_stall <= 1'b1;
        ostall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    exec_result_t exp_r, got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_write_value, out_taken, out_next_pc, out_halt, out_status};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_r = pending_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("expected wv=%h tk=%b npc=%h h=%b st=%0d got wv=%h tk=%b npc=%h h=%b st=%0d",
                     exp_r.wval, exp_r.taken, exp_r.npc, exp_r.halt, exp_r.status,
                     got.wval, got.taken, got.npc, got.halt, got.status);
        end
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // Loads a register with an arbitrary value via LUI and ADDI.
  task automatic load_reg(logic [4:0] rd, logic [31:0] v);
    logic [31:0] hi;
    hi = (v + 32'h800) >> 12;
    issue(rv32eu_pkg::OP_LUI, rd, 5'd0, 5'd0, hi, 12'd0, $urandom);
    issue(rv32eu_pkg::OP_ADDI, rd, rd, 5'd0, {{20{v[11]}}, v[11:0]}, 12'd0, $urandom);
  endtask

  task automatic test_directed();
    load_reg(5'd1, 32'h8000_0000);
    load_reg(5'd2, 32'hFFFF_FFFF);
    load_reg(5'd3, 32'h7FFF_FFFF);
    issue(rv32eu_pkg::OP_DIV, 5'd4, 5'd1, 5'd2, 32'd0, 12'd0, 32'hFFFF_FFFC);
    issue(rv32eu_pkg::OP_DIV, 5'd5, 5'd3, 5'd0, 32'd0, 12'd0, 32'h100);
    issue(rv32eu_pkg::OP_SW, 5'd0, 5'd1, 5'd3, 32'h7FFF_FFFF, 12'd0, 32'd0);
    issue(rv32eu_pkg::OP_LW, 5'd6, 5'd1, 5'd0, 32'h7FFF_FFFC, 12'd0, 32'd0);
    issue(rv32eu_pkg::OP_JALR, 5'd7, 5'd7, 5'd0, 32'h5, 12'd0, 32'h40);
    issue(rv32eu_pkg::OP_BLT, 5'd0, 5'd1, 5'd3, 32'hFFFF_FFF0, 12'd0, 32'h1000);
    issue(rv32eu_pkg::OP_BLTU, 5'd0, 5'd1, 5'd3, 32'h20, 12'd0, 32'h1000);
    issue(rv32eu_pkg::OP_SRAI, 5'd8, 5'd1, 5'd0, 32'hFFFF_FFFF, 12'd0, 32'd0);
    issue(rv32eu_pkg::OP_CSRRSI, 5'd9, 5'd31, 5'd0, 32'd0, 12'hFFF, 32'd0);
    issue(rv32eu_pkg::OP_CSRRC, 5'd10, 5'd2, 5'd0, 32'd0, 12'hFFF, 32'd0);
    issue(rv32eu_pkg::OP_CSRRW, 5'd2, 5'd2, 5'd0, 32'd0, 12'h000, 32'd0);
    issue(6'd63, 5'd11, 5'd2, 5'd2, 32'hFFFF_FFFF, 12'hFFF, 32'hFFFF_FFFF);
    issue(rv32eu_pkg::OP_ECALL, 5'd0, 5'd0, 5'd0, 32'd0, 12'd0, 32'h8);
    issue(rv32eu_pkg::OP_SW, 5'd0, 5'd1, 5'd2, 32'h0000_0003, 12'd0, 32'd0);
    for (int op = 0; op <= rv32eu_pkg::OP_CSRRCI; op++)
      issue(6'(op), 5'd12, 5'd1, 5'd2, 32'h0000_0003, 12'h010, 32'h2000);
  endtask

  task automatic test_random(int count);
    logic [5:0] op;
    logic [4:0] ra;
    logic [31:0] imm, addr;
    for (int n = 0; n < count; n++) begin
      ra = 5'($urandom);
      imm = rand_word();
      if ($urandom_range(0, 9) == 0) op = 6'($urandom_range(36, 63));
      else op = 6'($urandom_range(0, rv32eu_pkg::OP_CSRRCI));
      if (op == rv32eu_pkg::OP_LW) begin
        addr = gpr_read(ra) + imm;
        if (!dmem_set[word_index(addr)]) op = rv32eu_pkg::OP_SW;
        else if ($urandom_range(0, 1))
          imm = imm - {30'd0, addr[1:0]} + 32'($urandom_range(0, 3));
      end
      if (op == rv32eu_pkg::OP_DIV && $urandom_range(0, 3) != 0 && gpr_read(ra) == 0)
        ra = 5'd1;
      if (op == rv32eu_pkg::OP_SW && $urandom_range(0, 1))
        imm = 32'($urandom_range(0, 63)) << 2;
      addr = gpr_read(ra) + imm;
      issue(op, 5'($urandom), ra, 5'($urandom), imm,
            $urandom_range(0, 3) == 0 ? 12'($urandom) : 12'($urandom_range(0, 7)),
            rand_word());
      if (op == rv32eu_pkg::OP_SW && $urandom_range(0, 1))
        issue(rv32eu_pkg::OP_LW, 5'($urandom), ra, 5'd0,
              imm - {30'd0, addr[1:0]} + 32'($urandom_range(0, 3)), 12'd0, $urandom);
    end
  endtask

  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = 0;
    for (int i = 0; i < rv32eu_pkg::CSR_ENTRIES; i++) csrs[i] = 0;
    for (int i = 0; i < rv32eu_pkg::MEM_WORDS; i++) begin
      dmem[i] = 0; dmem_set[i] = 0;
    end
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(560);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("rv32_execute_unit: match");
    else $display("rv32_execute_unit: mismatch");
    $finish;
  end

  initial begin
    #2000000;
    $display("rv32_execute_unit: mismatch");
    $finish;
  end
endmodule
